// ===== rtl/core/tcas_pkg.sv =====
package tcas_pkg;

    // road geometry
    localparam int MAX_SITES        = 64;
    localparam int SITE_AW          = $clog2(MAX_SITES);
    localparam int LEN_W            = SITE_AW + 1;
    localparam int OPEN_CLEAR_SITES = 3;
    localparam int MIN_LEN          = 4;

    // site contents
    localparam int VEL_W = 4;
    localparam logic [VEL_W-1:0] EMPTY_SITE = 4'd15;
    localparam logic [VEL_W-1:0] VMAX_HI    = 4'd14;
    localparam logic [VEL_W-1:0] VMAX_LO    = 4'd1;

    // random generator
    localparam int RNG_W = 16;
    localparam logic [RNG_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [RNG_W-1:0] RNG_RESET = 16'd1;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    typedef enum logic [CFG_AW-1:0] {
        CFG_VMAX        = 3'd0,
        CFG_PERIODIC    = 3'd1,
        CFG_ROAD_LENGTH = 3'd2,
        CFG_THRESHOLD   = 3'd3,
        CFG_RNG_SEED    = 3'd4
    } tcas_cfg_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_READ = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } tcas_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_READ_RD,
        ST_READ_WAIT,
        ST_COUNT,
        ST_CLEAR,
        ST_SCAN,
        ST_LAST,
        ST_DRAIN,
        ST_COPY,
        ST_DONE
    } tcas_state_t;

    // one car handed to the velocity unit
    typedef struct packed {
        logic               vld;
        logic [SITE_AW-1:0] pos;
        logic [VEL_W-1:0]   vel;
        logic [LEN_W-1:0]   gap;
        logic               limited;
    } car_job_t;

    // write into the next-road store
    typedef struct packed {
        logic               en;
        logic [SITE_AW-1:0] addr;
        logic [VEL_W-1:0]   data;
    } next_wr_t;

endpackage

// ===== rtl/core/tcas_site_ram.sv =====
module tcas_site_ram (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [tcas_pkg::SITE_AW-1:0] waddr,
    input  logic [tcas_pkg::VEL_W-1:0]   wdata,
    input  logic [tcas_pkg::SITE_AW-1:0] raddr,
    output logic [tcas_pkg::VEL_W-1:0]   rdata
);

    logic [tcas_pkg::VEL_W-1:0]     mem [tcas_pkg::MAX_SITES];
    logic [tcas_pkg::MAX_SITES-1:0] vld_reg;
    logic [tcas_pkg::VEL_W-1:0]     mem_q_reg;
    logic                           vld_q_reg;

    // per-site written flags, a site never written reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[raddr];
        vld_q_reg <= vld_reg[raddr];
    end

    assign rdata = vld_q_reg ? mem_q_reg : tcas_pkg::EMPTY_SITE;

endmodule

// ===== rtl/core/tcas_next_ram.sv =====
module tcas_next_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [tcas_pkg::SITE_AW-1:0] waddr,
    input  logic [tcas_pkg::VEL_W-1:0]   wdata,
    input  logic [tcas_pkg::SITE_AW-1:0] raddr,
    output logic [tcas_pkg::VEL_W-1:0]   rdata
);

    logic [tcas_pkg::VEL_W-1:0] mem [tcas_pkg::MAX_SITES];
    logic [tcas_pkg::VEL_W-1:0] rdata_reg;

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tcas_car_update.sv =====
module tcas_car_update (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcas_pkg::car_job_t         job,
    input  logic [tcas_pkg::VEL_W-1:0] vm,
    input  logic                       ring,
    input  logic [tcas_pkg::LEN_W-1:0] len,
    input  logic [tcas_pkg::RNG_W-1:0] threshold,
    input  logic                       seed_load,
    input  logic [tcas_pkg::RNG_W-1:0] seed,
    output tcas_pkg::next_wr_t         wr
);

    tcas_pkg::car_job_t         job_reg;
    logic [tcas_pkg::RNG_W-1:0] rng_reg;
    logic [tcas_pkg::RNG_W-1:0] rng_next;
    logic [tcas_pkg::RNG_W-1:0] draw;
    logic [tcas_pkg::VEL_W:0]   vel_inc;
    logic [tcas_pkg::VEL_W-1:0] v_acc;
    logic [tcas_pkg::LEN_W-1:0] gap_m1;
    logic [tcas_pkg::VEL_W-1:0] v_brk;
    logic [tcas_pkg::VEL_W-1:0] v_rnd;
    logic [tcas_pkg::LEN_W-1:0] tgt;
    logic                       tgt_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg <= '0;
        end
        else
        begin
            job_reg <= job;
        end
    end

    // galois step, the new state is the draw
    always_comb
    begin
        draw = {1'b0, rng_reg[tcas_pkg::RNG_W-1:1]};
        if (rng_reg[0])
        begin
            draw = draw ^ tcas_pkg::LFSR_TAPS;
        end
    end

    always_comb
    begin
        rng_next = rng_reg;
        if (seed_load)
        begin
            rng_next = (seed == '0) ? tcas_pkg::RNG_RESET : seed;
        end
        else if (job_reg.vld)
        begin
            rng_next = draw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg <= tcas_pkg::RNG_RESET;
        end
        else
        begin
            rng_reg <= rng_next;
        end
    end

    // accelerate, brake to the gap, random slowdown, move
    always_comb
    begin
        vel_inc = {1'b0, job_reg.vel} + (tcas_pkg::VEL_W+1)'(1);
        v_acc   = (vel_inc < {1'b0, vm}) ? vel_inc[tcas_pkg::VEL_W-1:0] : vm;
        gap_m1  = job_reg.gap - tcas_pkg::LEN_W'(1);
        v_brk   = v_acc;
        if (job_reg.limited && (tcas_pkg::LEN_W'(v_acc) > gap_m1))
        begin
            v_brk = gap_m1[tcas_pkg::VEL_W-1:0];
        end
        v_rnd = v_brk;
        if ((draw < threshold) && (v_brk != '0))
        begin
            v_rnd = v_brk - tcas_pkg::VEL_W'(1);
        end
        tgt     = tcas_pkg::LEN_W'(job_reg.pos) + tcas_pkg::LEN_W'(v_rnd);
        tgt_out = (tgt >= len);
        if (tgt_out)
        begin
            tgt = tgt - len;
        end
        wr.en   = job_reg.vld && (!tgt_out || ring);
        wr.addr = tgt[tcas_pkg::SITE_AW-1:0];
        wr.data = v_rnd;
    end

endmodule

// ===== rtl/core/traffic_cellular_automaton_step.sv =====
// load: LOAD_RD, LOAD_WR, DONE; read: READ_RD, READ_WAIT, DONE; nop: DONE; after a road_length
//   write the next load, read or nop adds a recount pass (COUNT) before DONE
// tick: a CLEAR pass over the next-road store, a SCAN pass of the site store read port,
//   then LAST, DRAIN and a COPY pass of the next-road store read port
// one word in work at a time; a new word is taken while the last result waits
// reset: road empty through per-site written flags, no clearing pass; the next-road store
//   is cleared lazily by the first tick that reaches those sites
module traffic_cellular_automaton_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [tcas_pkg::SITE_AW-1:0] site_index,
    input  logic [tcas_pkg::VEL_W-1:0]  site_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tcas_pkg::VEL_W-1:0]  read_value,
    output logic [tcas_pkg::LEN_W-1:0]  car_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcas_pkg::CFG_AW-1:0] cfg_index,
    input  logic [tcas_pkg::CFG_DW-1:0] cfg_data
);

    // configuration registers
    logic [tcas_pkg::VEL_W-1:0] vmax_reg;
    logic                       periodic_reg;
    logic [tcas_pkg::LEN_W-1:0] road_length_reg;
    logic [tcas_pkg::RNG_W-1:0] threshold_reg;
    logic                       cfg_wr;

    // sequencer
    tcas_pkg::tcas_state_t state_reg, state_next;

    // item word
    logic [tcas_pkg::SITE_AW-1:0] idx_reg, idx_next;
    logic [tcas_pkg::VEL_W-1:0]   val_reg, val_next;

    // pass control: address pointer, read in flight and its site
    logic [tcas_pkg::LEN_W-1:0]   ptr_reg, ptr_next;
    logic                         pv_reg, pv_next;
    logic [tcas_pkg::SITE_AW-1:0] pp_reg, pp_next;
    logic [tcas_pkg::LEN_W-1:0]   acc_reg, acc_next;

    // running car count, valid unless road_length changed since
    logic [tcas_pkg::LEN_W-1:0]   count_reg, count_next;
    logic                         dirty_reg, dirty_next;
    // next-road sites below this are known empty
    logic [tcas_pkg::LEN_W-1:0]   clean_reg, clean_next;

    // scan tracking: previous car seen and the first car of the road
    logic                         have_prev_reg, have_prev_next;
    logic [tcas_pkg::SITE_AW-1:0] prev_pos_reg, prev_pos_next;
    logic [tcas_pkg::VEL_W-1:0]   prev_vel_reg, prev_vel_next;
    logic [tcas_pkg::SITE_AW-1:0] first_pos_reg, first_pos_next;

    // result
    logic [tcas_pkg::VEL_W-1:0]   rd_reg, rd_next;
    logic                         out_valid_reg, out_valid_next;
    logic [tcas_pkg::VEL_W-1:0]   out_rd_reg, out_rd_next;
    logic [tcas_pkg::LEN_W-1:0]   out_cnt_reg, out_cnt_next;

    // derived limits
    logic [tcas_pkg::LEN_W-1:0]   len_c;
    logic [tcas_pkg::VEL_W-1:0]   vm_c;
    logic                         ring;
    logic                         issue;
    logic                         pass_end;
    logic                         in_road;
    logic                         out_free;

    // memory ports
    logic                         site_we;
    logic [tcas_pkg::SITE_AW-1:0] site_waddr;
    logic [tcas_pkg::VEL_W-1:0]   site_wdata;
    logic [tcas_pkg::SITE_AW-1:0] site_raddr;
    logic [tcas_pkg::VEL_W-1:0]   site_rdata;
    logic                         nxt_we;
    logic [tcas_pkg::SITE_AW-1:0] nxt_waddr;
    logic [tcas_pkg::VEL_W-1:0]   nxt_wdata;
    logic [tcas_pkg::SITE_AW-1:0] nxt_raddr;
    logic [tcas_pkg::VEL_W-1:0]   nxt_rdata;
    logic [tcas_pkg::VEL_W-1:0]   cp_val;

    tcas_pkg::car_job_t job;
    tcas_pkg::next_wr_t car_wr;

    // ---------------------------------------------------------------------
    // configuration port, always ready
    // ---------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmax_reg        <= 4'd5;
            periodic_reg    <= 1'b1;
            road_length_reg <= tcas_pkg::LEN_W'(tcas_pkg::MAX_SITES);
            threshold_reg   <= 16'd6554;
        end
        else if (cfg_wr)
        begin
            case (tcas_pkg::tcas_cfg_t'(cfg_index))
                tcas_pkg::CFG_VMAX:
                begin
                    vmax_reg <= cfg_data[tcas_pkg::VEL_W-1:0];
                end
                tcas_pkg::CFG_PERIODIC:
                begin
                    periodic_reg <= cfg_data[0];
                end
                tcas_pkg::CFG_ROAD_LENGTH:
                begin
                    road_length_reg <= cfg_data[tcas_pkg::LEN_W-1:0];
                end
                tcas_pkg::CFG_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[tcas_pkg::RNG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // clamp road length and speed limit into their working ranges
    always_comb
    begin
        len_c = road_length_reg;
        if (road_length_reg < tcas_pkg::LEN_W'(tcas_pkg::MIN_LEN))
        begin
            len_c = tcas_pkg::LEN_W'(tcas_pkg::MIN_LEN);
        end
        else if (road_length_reg > tcas_pkg::LEN_W'(tcas_pkg::MAX_SITES))
        begin
            len_c = tcas_pkg::LEN_W'(tcas_pkg::MAX_SITES);
        end
        vm_c = vmax_reg;
        if (vmax_reg < tcas_pkg::VMAX_LO)
        begin
            vm_c = tcas_pkg::VMAX_LO;
        end
        else if (vmax_reg > tcas_pkg::VMAX_HI)
        begin
            vm_c = tcas_pkg::VMAX_HI;
        end
    end

    assign ring     = periodic_reg;
    assign issue    = (ptr_reg < len_c);
    assign pass_end = !issue && !pv_reg;
    assign in_road  = (tcas_pkg::LEN_W'(idx_reg) < len_c);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == tcas_pkg::ST_IDLE);

    // ---------------------------------------------------------------------
    // storage
    // ---------------------------------------------------------------------
    tcas_site_ram u_site_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (site_we),
        .waddr (site_waddr),
        .wdata (site_wdata),
        .raddr (site_raddr),
        .rdata (site_rdata)
    );

    tcas_next_ram u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    // velocity rule and random generator, one car per cycle at most
    tcas_car_update u_car_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .vm        (vm_c),
        .ring      (ring),
        .len       (len_c),
        .threshold (threshold_reg),
        .seed_load (cfg_wr && (tcas_pkg::tcas_cfg_t'(cfg_index) == tcas_pkg::CFG_RNG_SEED)),
        .seed      (cfg_data[tcas_pkg::RNG_W-1:0]),
        .wr        (car_wr)
    );

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (tcas_pkg::tcas_op_t'(operation))
                        tcas_pkg::OP_LOAD: state_next = tcas_pkg::ST_LOAD_RD;
                        tcas_pkg::OP_READ: state_next = tcas_pkg::ST_READ_RD;
                        tcas_pkg::OP_TICK: state_next = tcas_pkg::ST_CLEAR;
                        default:
                        begin
                            state_next = dirty_reg ? tcas_pkg::ST_COUNT : tcas_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            tcas_pkg::ST_LOAD_RD:   state_next = tcas_pkg::ST_LOAD_WR;
            tcas_pkg::ST_READ_RD:   state_next = tcas_pkg::ST_READ_WAIT;
            tcas_pkg::ST_LOAD_WR,
            tcas_pkg::ST_READ_WAIT:
            begin
                state_next = dirty_reg ? tcas_pkg::ST_COUNT : tcas_pkg::ST_DONE;
            end
            tcas_pkg::ST_COUNT:
            begin
                if (pass_end)
                begin
                    state_next = tcas_pkg::ST_DONE;
                end
            end
            tcas_pkg::ST_CLEAR:
            begin
                if (!issue)
                begin
                    state_next = tcas_pkg::ST_SCAN;
                end
            end
            tcas_pkg::ST_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = tcas_pkg::ST_LAST;
                end
            end
            tcas_pkg::ST_LAST:  state_next = tcas_pkg::ST_DRAIN;
            tcas_pkg::ST_DRAIN: state_next = tcas_pkg::ST_COPY;
            tcas_pkg::ST_COPY:
            begin
                if (pass_end)
                begin
                    state_next = tcas_pkg::ST_DONE;
                end
            end
            tcas_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tcas_pkg::ST_IDLE;
                end
            end
            default: state_next = tcas_pkg::ST_IDLE;
        endcase
    end

    // open road: clear the last sites, then put a stopped car on an empty site 0
    always_comb
    begin
        cp_val = nxt_rdata;
        if (!ring)
        begin
            if ((tcas_pkg::LEN_W'(pp_reg) + tcas_pkg::LEN_W'(tcas_pkg::OPEN_CLEAR_SITES))
                >= len_c)
            begin
                cp_val = tcas_pkg::EMPTY_SITE;
            end
            else if ((pp_reg == '0) && (nxt_rdata == tcas_pkg::EMPTY_SITE))
            begin
                cp_val = '0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // datapath and memory control
    // ---------------------------------------------------------------------
    always_comb
    begin
        idx_next       = idx_reg;
        val_next       = val_reg;
        ptr_next       = ptr_reg;
        pv_next        = 1'b0;
        pp_next        = pp_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        dirty_next     = dirty_reg;
        clean_next     = clean_reg;
        have_prev_next = have_prev_reg;
        prev_pos_next  = prev_pos_reg;
        prev_vel_next  = prev_vel_reg;
        first_pos_next = first_pos_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rd_next    = out_rd_reg;
        out_cnt_next   = out_cnt_reg;

        site_raddr = idx_reg;
        site_we    = 1'b0;
        site_waddr = pp_reg;
        site_wdata = tcas_pkg::EMPTY_SITE;
        nxt_raddr  = ptr_reg[tcas_pkg::SITE_AW-1:0];
        nxt_we     = car_wr.en;
        nxt_waddr  = car_wr.addr;
        nxt_wdata  = car_wr.data;
        job        = '0;

        // a new road length invalidates the running count
        if (cfg_wr && (tcas_pkg::tcas_cfg_t'(cfg_index) == tcas_pkg::CFG_ROAD_LENGTH))
        begin
            dirty_next = 1'b1;
        end

        case (state_reg)
            tcas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = site_index;
                    val_next = site_value;
                    rd_next  = '0;
                    acc_next = '0;
                    // a tick starts by clearing whatever of the next road is not yet clean
                    ptr_next = (tcas_pkg::tcas_op_t'(operation) == tcas_pkg::OP_TICK) ?
                               clean_reg : '0;
                end
            end
            tcas_pkg::ST_LOAD_RD,
            tcas_pkg::ST_READ_RD:
            begin
                site_raddr = idx_reg;
            end
            tcas_pkg::ST_LOAD_WR:
            begin
                if (in_road)
                begin
                    site_we    = 1'b1;
                    site_waddr = idx_reg;
                    site_wdata = val_reg;
                    count_next = count_reg
                               - tcas_pkg::LEN_W'(site_rdata != tcas_pkg::EMPTY_SITE)
                               + tcas_pkg::LEN_W'(val_reg != tcas_pkg::EMPTY_SITE);
                end
                ptr_next = '0;
                acc_next = '0;
            end
            tcas_pkg::ST_READ_WAIT:
            begin
                rd_next  = in_road ? site_rdata : tcas_pkg::EMPTY_SITE;
                ptr_next = '0;
                acc_next = '0;
            end
            tcas_pkg::ST_COUNT:
            begin
                site_raddr = ptr_reg[tcas_pkg::SITE_AW-1:0];
                if (issue)
                begin
                    pv_next  = 1'b1;
                    pp_next  = ptr_reg[tcas_pkg::SITE_AW-1:0];
                    ptr_next = ptr_reg + tcas_pkg::LEN_W'(1);
                end
                if (pv_reg && (site_rdata != tcas_pkg::EMPTY_SITE))
                begin
                    acc_next = acc_reg + tcas_pkg::LEN_W'(1);
                end
                if (pass_end)
                begin
                    count_next = acc_reg;
                    dirty_next = 1'b0;
                end
            end
            tcas_pkg::ST_CLEAR:
            begin
                if (issue)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = ptr_reg[tcas_pkg::SITE_AW-1:0];
                    nxt_wdata = tcas_pkg::EMPTY_SITE;
                    ptr_next  = ptr_reg + tcas_pkg::LEN_W'(1);
                end
                else
                begin
                    ptr_next       = '0;
                    have_prev_next = 1'b0;
                end
            end
            tcas_pkg::ST_SCAN:
            begin
                site_raddr = ptr_reg[tcas_pkg::SITE_AW-1:0];
                if (issue)
                begin
                    pv_next  = 1'b1;
                    pp_next  = ptr_reg[tcas_pkg::SITE_AW-1:0];
                    ptr_next = ptr_reg + tcas_pkg::LEN_W'(1);
                end
                // a car found here fixes the gap of the car behind it
                if (pv_reg && (site_rdata != tcas_pkg::EMPTY_SITE))
                begin
                    if (have_prev_reg)
                    begin
                        job.vld     = 1'b1;
                        job.pos     = prev_pos_reg;
                        job.vel     = prev_vel_reg;
                        job.gap     = tcas_pkg::LEN_W'(pp_reg) - tcas_pkg::LEN_W'(prev_pos_reg);
                        job.limited = 1'b1;
                    end
                    else
                    begin
                        first_pos_next = pp_reg;
                    end
                    have_prev_next = 1'b1;
                    prev_pos_next  = pp_reg;
                    prev_vel_next  = site_rdata;
                end
            end
            tcas_pkg::ST_LAST:
            begin
                // last car: ring gap wraps round to the first car, open road has no limit
                job.vld     = have_prev_reg;
                job.pos     = prev_pos_reg;
                job.vel     = prev_vel_reg;
                job.gap     = len_c - (tcas_pkg::LEN_W'(prev_pos_reg)
                                     - tcas_pkg::LEN_W'(first_pos_reg));
                job.limited = ring;
            end
            tcas_pkg::ST_DRAIN:
            begin
                ptr_next = '0;
                acc_next = '0;
            end
            tcas_pkg::ST_COPY:
            begin
                // copy next road into the site store, leaving the next road clean
                nxt_raddr = ptr_reg[tcas_pkg::SITE_AW-1:0];
                if (issue)
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = ptr_reg[tcas_pkg::SITE_AW-1:0];
                    nxt_wdata = tcas_pkg::EMPTY_SITE;
                    pv_next   = 1'b1;
                    pp_next   = ptr_reg[tcas_pkg::SITE_AW-1:0];
                    ptr_next  = ptr_reg + tcas_pkg::LEN_W'(1);
                end
                if (pv_reg)
                begin
                    site_we    = 1'b1;
                    site_waddr = pp_reg;
                    site_wdata = cp_val;
                    if (cp_val != tcas_pkg::EMPTY_SITE)
                    begin
                        acc_next = acc_reg + tcas_pkg::LEN_W'(1);
                    end
                end
                if (pass_end)
                begin
                    count_next = acc_reg;
                    dirty_next = 1'b0;
                    if (len_c > clean_reg)
                    begin
                        clean_next = len_c;
                    end
                end
            end
            tcas_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_cnt_next   = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcas_pkg::ST_IDLE;
            ptr_reg       <= '0;
            pv_reg        <= 1'b0;
            count_reg     <= '0;
            dirty_reg     <= 1'b0;
            clean_reg     <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            pv_reg        <= pv_next;
            count_reg     <= count_next;
            dirty_reg     <= dirty_next;
            clean_reg     <= clean_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        pp_reg        <= pp_next;
        acc_reg       <= acc_next;
        prev_pos_reg  <= prev_pos_next;
        prev_vel_reg  <= prev_vel_next;
        first_pos_reg <= first_pos_next;
        rd_reg        <= rd_next;
        out_rd_reg    <= out_rd_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_rd_reg;
    assign car_count  = out_cnt_reg;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcas_pkg::*;

    // quiet cycles allowed before the run is called hung: slowest tick with a cold
    // next-road store, longest output stall, longest sender gap and the settle wait
    localparam int WATCHDOG_LIMIT = 4000;
    // cycles left after the last result so that a tick or recount can finish
    localparam int SETTLE_CYCLES  = 200;
    localparam int RANDOM_PHASES  = 10;
    localparam int MIXED_WORDS    = 60;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          operation;
    logic [SITE_AW-1:0]  site_index;
    logic [VEL_W-1:0]    site_value;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [VEL_W-1:0]    read_value;
    logic [LEN_W-1:0]    car_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_AW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;

    // no idling on either side while this is set
    bit calm = 1'b0;

    typedef struct {
        logic [VEL_W-1:0] rd;
        logic [LEN_W-1:0] cnt;
    } road_result_t;

    // road predictor and the results it still owes
    class road_scoreboard;
        logic [VEL_W-1:0] road [MAX_SITES];
        logic [RNG_W-1:0] lfsr;
        logic [3:0]       vmax_r;
        logic             periodic_r;
        logic [6:0]       length_r;
        logic [15:0]      thresh_r;
        road_result_t     owed_q [$];
        int               errors;
        int               checked;
        int               n_load;
        int               n_read;
        int               n_tick;
        int               n_nop;

        function new();
            for (int i = 0; i < MAX_SITES; i++)
                road[i] = EMPTY_SITE;
            lfsr       = RNG_RESET;
            vmax_r     = 4'd5;
            periodic_r = 1'b1;
            length_r   = 7'd64;
            thresh_r   = 16'd6554;
            errors     = 0;
            checked    = 0;
            n_load     = 0;
            n_read     = 0;
            n_tick     = 0;
            n_nop      = 0;
        endfunction

        function int road_sites();
            int len;
            len = length_r;
            if (len < MIN_LEN)
                len = MIN_LEN;
            if (len > MAX_SITES)
                len = MAX_SITES;
            return len;
        endfunction

        function int speed_cap();
            if (vmax_r < VMAX_LO)
                return VMAX_LO;
            if (vmax_r > VMAX_HI)
                return VMAX_HI;
            return vmax_r;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void set_reg(tcas_cfg_t idx, logic [CFG_DW-1:0] d);
            case (idx)
                CFG_VMAX:        vmax_r     = d[3:0];
                CFG_PERIODIC:    periodic_r = d[0];
                CFG_ROAD_LENGTH: length_r   = d[6:0];
                CFG_THRESHOLD:   thresh_r   = d;
                CFG_RNG_SEED:    lfsr       = (d == 16'd0) ? RNG_RESET : d;
                default: ;
            endcase
        endfunction

        // apply one accepted word to the road and queue the result it causes
        function void note_word(tcas_op_t op, logic [SITE_AW-1:0] idx, logic [VEL_W-1:0] val);
            int               len;
            int               vm;
            int               v;
            int               gap;
            int               pos;
            int               target;
            int               cnt;
            bit               ring;
            bit               limited;
            logic             lsb;
            logic [VEL_W-1:0] nxt [MAX_SITES];
            road_result_t     r;
            len  = road_sites();
            r.rd = '0;
            case (op)
                OP_LOAD:
                begin
                    n_load++;
                    if (idx < len)
                        road[idx] = val;
                end
                OP_READ:
                begin
                    n_read++;
                    r.rd = (idx < len) ? road[idx] : EMPTY_SITE;
                end
                OP_TICK:
                begin
                    n_tick++;
                    vm   = speed_cap();
                    ring = periodic_r;
                    for (int i = 0; i < len; i++)
                        nxt[i] = EMPTY_SITE;
                    // every car looks at the road as it was before the tick
                    for (int i = 0; i < len; i++)
                    begin
                        if (road[i] == EMPTY_SITE)
                            continue;
                        v       = road[i];
                        gap     = len;
                        limited = 1'b0;
                        for (int k = 1; k < len; k++)
                        begin
                            pos = i + k;
                            if (pos >= len)
                            begin
                                if (!ring)
                                    break;
                                pos -= len;
                            end
                            if (road[pos] != EMPTY_SITE)
                            begin
                                gap     = k;
                                limited = 1'b1;
                                break;
                            end
                        end
                        // a lone car on a ring sees itself a full lap ahead
                        if (ring)
                            limited = 1'b1;
                        v = (v + 1 < vm) ? v + 1 : vm;
                        if (limited && v > gap - 1)
                            v = gap - 1;
                        lsb  = lfsr[0];
                        lfsr = lfsr >> 1;
                        if (lsb)
                            lfsr = lfsr ^ LFSR_TAPS;
                        if (lfsr < thresh_r && v > 0)
                            v--;
                        target = i + v;
                        if (target >= len)
                        begin
                            if (!ring)
                                continue;
                            target -= len;
                        end
                        nxt[target] = v[VEL_W-1:0];
                    end
                    // open road: clear the exit sites, then inject at the entry
                    if (!ring)
                    begin
                        for (int k = 1; k <= OPEN_CLEAR_SITES; k++)
                            if (k <= len)
                                nxt[len - k] = EMPTY_SITE;
                        if (nxt[0] == EMPTY_SITE)
                            nxt[0] = '0;
                    end
                    for (int i = 0; i < len; i++)
                        road[i] = nxt[i];
                end
                default: n_nop++;
            endcase
            cnt = 0;
            for (int i = 0; i < len; i++)
                if (road[i] != EMPTY_SITE)
                    cnt++;
            r.cnt = cnt[LEN_W-1:0];
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void check_word(logic [VEL_W-1:0] rd, logic [LEN_W-1:0] cnt);
            road_result_t e;
            if (owed_q.size() == 0)
            begin
                $error("result with no word pending: read_value %0d car_count %0d", rd, cnt);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            checked++;
            if (rd !== e.rd)
            begin
                $error("read_value mismatch: expected %0d, actual %0d", e.rd, rd);
                errors++;
            end
            if (cnt !== e.cnt)
            begin
                $error("car_count mismatch: expected %0d, actual %0d", e.cnt, cnt);
                errors++;
            end
        endfunction
    endclass

    road_scoreboard sb;
    int             settings_used = 0;
    int             quiet_cycles  = 0;

    traffic_cellular_automaton_step dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .site_index (site_index),
        .site_value (site_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .car_count  (car_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle stretch: mostly short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver side: random stall stretches, none while calm
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // every accepted result goes against the oldest owed one
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_word(read_value, car_count);
    end

    // hang detector: no word moving on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // offer one word at a falling edge; valid is left high for a following word,
    // so anything other than another send must go through drain_words first
    task automatic send_word(tcas_op_t op, int idx, int val);
        int gap;
        in_valid   <= 1'b1;
        operation  <= op;
        site_index <= idx[SITE_AW-1:0];
        site_value <= val[VEL_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(op, idx[SITE_AW-1:0], val[VEL_W-1:0]);
        @(negedge clk);
        if (!calm && $urandom_range(0, 9) < 4)
        begin
            gap = idle_len();
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop sending and wait for every owed result, then the given number of extra cycles
    task automatic drain_words(int extra);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
        @(negedge clk);
    endtask

    // write all five registers back to back; only called with the block idle
    task automatic program_road(int vm, int per, int len, int thr, int seed);
        tcas_cfg_t  idx [5];
        logic [15:0] dat [5];
        idx[0] = CFG_VMAX;        dat[0] = vm[15:0];
        idx[1] = CFG_PERIODIC;    dat[1] = per[15:0];
        idx[2] = CFG_ROAD_LENGTH; dat[2] = len[15:0];
        idx[3] = CFG_THRESHOLD;   dat[3] = thr[15:0];
        idx[4] = CFG_RNG_SEED;    dat[4] = seed[15:0];
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= dat[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(idx[i], dat[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    initial
    begin
        int len;
        int vm;
        int density;
        int r;
        int vm_cfg;
        int len_cfg;
        int thr_cfg;
        int per_cfg;
        int val;

        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_NOP;
        site_index = '0;
        site_value = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_VMAX;
        cfg_data   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset road: empty at both ends, then a nop with every field bit high
        send_word(OP_READ, 0, 0);
        send_word(OP_READ, 63, 0);
        send_word(OP_NOP, 63, 15);
        // ring wrap: a car on the last site sits right behind the one on site 0,
        // and a loaded speed above vmax gets cut at the tick
        send_word(OP_LOAD, 0, 14);
        send_word(OP_LOAD, 63, 0);
        send_word(OP_LOAD, 1, 15);
        send_word(OP_LOAD, 2, 7);
        send_word(OP_READ, 0, 0);
        send_word(OP_TICK, 0, 0);
        send_word(OP_TICK, 0, 0);
        send_word(OP_READ, 1, 0);

        // short open road (length below the floor), top vmax code, always slow,
        // seed of zero
        drain_words(SETTLE_CYCLES);
        program_road(15, 0, 2, 65535, 0);
        // load beyond the road is dropped and a read there returns empty
        send_word(OP_LOAD, 10, 3);
        send_word(OP_READ, 10, 0);
        // injection on an empty road, then exit past the end with the clear
        send_word(OP_TICK, 0, 0);
        send_word(OP_TICK, 0, 0);
        send_word(OP_READ, 0, 0);
        send_word(OP_LOAD, 3, 2);
        send_word(OP_TICK, 0, 0);
        send_word(OP_READ, 3, 0);

        // length code above the road size, vmax code zero, never slow,
        // a lone car on a ring
        drain_words(SETTLE_CYCLES);
        program_road(0, 1, 127, 0, 16'hFFFF);
        for (int s = 0; s < 4; s++)
            send_word(OP_LOAD, s, 15);
        send_word(OP_LOAD, 5, 1);
        send_word(OP_TICK, 0, 0);
        send_word(OP_TICK, 0, 0);
        send_word(OP_READ, 7, 0);

        // random phases: fill the road, then mostly ticks with reads and noise
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin vm_cfg = 14; len_cfg = 4;  thr_cfg = 0;     per_cfg = 1; end
                1: begin vm_cfg = 1;  len_cfg = 64; thr_cfg = 65535; per_cfg = 0; end
                2: begin vm_cfg = 14; len_cfg = 64; thr_cfg = 0;     per_cfg = 0; end
                3: begin vm_cfg = 1;  len_cfg = 4;  thr_cfg = 65535; per_cfg = 1; end
                default:
                begin
                    vm_cfg  = $urandom_range(1, 14);
                    len_cfg = $urandom_range(4, 64);
                    thr_cfg = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 16000);
                    per_cfg = $urandom_range(0, 1);
                end
            endcase
            calm = (phase == 5);
            drain_words(SETTLE_CYCLES);
            program_road(vm_cfg, per_cfg, len_cfg, thr_cfg, $urandom_range(0, 65535));
            len     = sb.road_sites();
            vm      = sb.speed_cap();
            density = $urandom_range(10, 90);

            for (int s = 0; s < len; s++)
            begin
                if ($urandom_range(0, 19) == 0)
                    val = $urandom_range(0, 15);
                else if ($urandom_range(0, 99) < density)
                    val = $urandom_range(0, vm);
                else
                    val = EMPTY_SITE;
                send_word(OP_LOAD, s, val);
            end

            for (int n = 0; n < MIXED_WORDS; n++)
            begin
                // sender holds off until the block has answered everything
                if (n == MIXED_WORDS / 2)
                    drain_words(0);
                r = $urandom_range(0, 99);
                if (r < 45)
                    send_word(OP_TICK, $urandom_range(0, 63), $urandom_range(0, 15));
                else if (r < 70)
                    send_word(OP_READ,
                              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, len - 1),
                              $urandom_range(0, 15));
                else if (r < 88)
                    send_word(OP_LOAD, $urandom_range(0, len - 1),
                              ($urandom_range(0, 3) == 0) ? EMPTY_SITE : $urandom_range(0, vm));
                else if (r < 94)
                    send_word(OP_NOP, $urandom_range(0, 63), $urandom_range(0, 15));
                else
                    send_word(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 15));
            end
        end

        calm = 1'b0;
        drain_words(SETTLE_CYCLES);

        $display("run covered %0d loads, %0d reads, %0d ticks and %0d nops",
                 sb.n_load, sb.n_read, sb.n_tick, sb.n_nop);
        $display("over %0d register settings; %0d results checked, %0d mismatches",
                 settings_used, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
